// ===== src/samr_pkg.sv =====
`timescale 1ns / 1ps
// shared types, sizes and codes for the saturating audio mix ring
package samr_pkg;

	localparam int FRAME_LEN   = 32;
	localparam int FRAME_COUNT = 8;
	localparam int RING_SIZE   = FRAME_LEN * FRAME_COUNT;
	localparam int RING_AW     = $clog2(RING_SIZE);
	localparam int FL_W        = (FRAME_LEN > 1) ? $clog2(FRAME_LEN) : 1;
	localparam int POS_W       = 8;
	localparam int SMP_W       = 16;

	localparam logic signed [SMP_W-1:0] SMP_MAX = 16'sh7FFF;
	localparam logic signed [SMP_W-1:0] SMP_MIN = -16'sh8000;

	localparam logic CMD_MIX    = 1'b0;
	localparam logic CMD_DRAIN  = 1'b1;
	localparam logic KIND_MIX   = 1'b0;
	localparam logic KIND_DRAIN = 1'b1;

	typedef struct packed {
		logic                    cmd;
		logic [POS_W-1:0]        write_pos;
		logic signed [SMP_W-1:0] sample;
		logic                    end_of_batch;
	} samr_item_t;

	typedef struct packed {
		logic                    kind;
		logic [POS_W-1:0]        next_pos;
		logic                    accepted;
		logic                    batch_done;
		logic signed [SMP_W-1:0] out_sample;
		logic                    last;
		logic [POS_W-1:0]        start_hint;
	} samr_result_t;

	// one ring access handed from the issue stage to the update stage
	typedef struct packed {
		logic                    drain;
		logic                    accepted;
		logic                    eob;
		logic                    last;
		logic [RING_AW-1:0]      addr;
		logic [RING_AW-1:0]      next_pos;
		logic [RING_AW-1:0]      hint;
		logic signed [SMP_W-1:0] sample;
	} samr_req_t;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_DRAIN = 2'b10
	} samr_state_t;

endpackage

// ===== src/saturating_audio_mix_ring.sv =====
`timescale 1ns / 1ps
// top level of the saturating audio mix ring
//
// Usage: a command transaction is taken at a rising edge with start high and busy low.
// item.cmd selects a mix (add item.sample into the ring at item.write_pos with
// 16-bit saturation) or a drain (emit the frame at the play position, clear it,
// move play one frame on). A mix at the play position is rejected untouched.
// Each result appears on result for exactly one cycle with result_strobe high;
// the receiver cannot stall, so it must take every strobed result.
// The first result of a transaction passes the issue register req_s1 and the result register before it is strobed.
// Mixes can be issued every cycle; a drain holds busy after accept until the last
// sample of its frame has been issued, and streams one sample per cycle, set by the
// single read port of the ring memory (one read per cycle).
// Back-to-back accesses to the same entry are forwarded around the memory.
// Reset (arst_n low) clears the play position and marks every ring entry as
// zero through per-entry valid bits, so no clearing pass is needed.
module saturating_audio_mix_ring (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  samr_pkg::samr_item_t   item,
	output samr_pkg::samr_result_t result,
	output logic                   result_strobe
);

	logic                              rd_en;
	logic [samr_pkg::RING_AW-1:0]      rd_addr;
	logic signed [samr_pkg::SMP_W-1:0] rd_data;
	logic                              wr_en;
	logic [samr_pkg::RING_AW-1:0]      wr_addr;
	logic signed [samr_pkg::SMP_W-1:0] wr_data;
	logic                              vld_s1;
	samr_pkg::samr_req_t               req_s1;

	samr_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.item    (item),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.vld_s1  (vld_s1),
		.req_s1  (req_s1)
	);

	samr_ram u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	samr_upd u_upd (
		.clk           (clk),
		.arst_n        (arst_n),
		.vld_s1        (vld_s1),
		.req_s1        (req_s1),
		.rd_data       (rd_data),
		.wr_en         (wr_en),
		.wr_addr       (wr_addr),
		.wr_data       (wr_data),
		.result        (result),
		.result_strobe (result_strobe)
	);

endmodule

// ===== src/samr_ram.sv =====
`timescale 1ns / 1ps
// sample ring memory with per-entry valid bits, unwritten entries read as zero
module samr_ram (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  rd_en,
	input  logic [samr_pkg::RING_AW-1:0]          rd_addr,
	output logic signed [samr_pkg::SMP_W-1:0]     rd_data,
	input  logic                                  wr_en,
	input  logic [samr_pkg::RING_AW-1:0]          wr_addr,
	input  logic signed [samr_pkg::SMP_W-1:0]     wr_data
);

	logic signed [samr_pkg::SMP_W-1:0] mem [samr_pkg::RING_SIZE];
	logic [samr_pkg::RING_SIZE-1:0]    vld_q;
	logic signed [samr_pkg::SMP_W-1:0] rd_q;
	logic                              rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_q : '0;

endmodule

// ===== src/samr_ctrl.sv =====
`timescale 1ns / 1ps
// issue stage: command decode, play position and drain sequencer
module samr_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  samr_pkg::samr_item_t         item,
	output logic                         rd_en,
	output logic [samr_pkg::RING_AW-1:0] rd_addr,
	output logic                         vld_s1,
	output samr_pkg::samr_req_t          req_s1
);

	samr_pkg::samr_state_t        state_q;
	logic [samr_pkg::RING_AW-1:0] play_q;
	logic [samr_pkg::FL_W-1:0]    cnt_q;
	logic                         accept;
	logic                         drain_last;
	logic [samr_pkg::RING_AW-1:0] pos_in;
	logic [samr_pkg::RING_AW:0]   pos_inc;
	logic [samr_pkg::RING_AW:0]   play_adv;
	logic [samr_pkg::RING_AW:0]   hint_sum;
	logic [samr_pkg::RING_AW-1:0] play_nxt;
	logic [samr_pkg::RING_AW-1:0] hint;
	samr_pkg::samr_req_t          req_d;

	assign busy   = (state_q == samr_pkg::ST_DRAIN);
	assign accept = start && !busy;
	assign pos_in = samr_pkg::RING_AW'(item.write_pos % samr_pkg::RING_SIZE);

	assign pos_inc  = (samr_pkg::RING_AW+1)'(pos_in) + 1'b1;
	assign play_adv = (samr_pkg::RING_AW+1)'(play_q)
		+ (samr_pkg::RING_AW+1)'(samr_pkg::FRAME_LEN);
	assign hint_sum = (samr_pkg::RING_AW+1)'(play_q)
		+ (samr_pkg::RING_AW+1)'(2 * samr_pkg::FRAME_LEN);
	assign play_nxt = (play_adv == (samr_pkg::RING_AW+1)'(samr_pkg::RING_SIZE))
		? '0 : play_adv[samr_pkg::RING_AW-1:0];
	assign hint = (hint_sum >= (samr_pkg::RING_AW+1)'(samr_pkg::RING_SIZE))
		? samr_pkg::RING_AW'(hint_sum - (samr_pkg::RING_AW+1)'(samr_pkg::RING_SIZE))
		: hint_sum[samr_pkg::RING_AW-1:0];

	// cnt is zero when idle, so a fresh drain sees its first entry here too
	assign drain_last = (cnt_q == samr_pkg::FL_W'(samr_pkg::FRAME_LEN - 1));

	always_comb begin
		req_d          = '0;
		req_d.hint     = hint;
		req_d.sample   = item.sample;
		req_d.eob      = item.end_of_batch;
		rd_en          = 1'b0;
		if (busy || (accept && item.cmd == samr_pkg::CMD_DRAIN)) begin
			rd_en          = 1'b1;
			req_d.drain    = 1'b1;
			req_d.addr     = play_q + samr_pkg::RING_AW'(cnt_q);
			req_d.last     = drain_last;
			req_d.eob      = 1'b0;
		end else if (accept) begin
			rd_en          = 1'b1;
			req_d.addr     = pos_in;
			req_d.last     = 1'b1;
			req_d.accepted = (pos_in != play_q);
			if (pos_in == play_q) begin
				req_d.next_pos = pos_in;
			end else if (pos_inc == (samr_pkg::RING_AW+1)'(samr_pkg::RING_SIZE)) begin
				req_d.next_pos = '0;
			end else begin
				req_d.next_pos = pos_inc[samr_pkg::RING_AW-1:0];
			end
		end
	end

	assign rd_addr = req_d.addr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= samr_pkg::ST_IDLE;
			play_q  <= '0;
			cnt_q   <= '0;
			vld_s1  <= 1'b0;
		end else begin
			vld_s1 <= rd_en;
			case (state_q)
				samr_pkg::ST_IDLE: begin
					if (accept && item.cmd == samr_pkg::CMD_DRAIN) begin
						if (drain_last) begin
							play_q <= play_nxt;
						end else begin
							state_q <= samr_pkg::ST_DRAIN;
							cnt_q   <= cnt_q + 1'b1;
						end
					end
				end
				samr_pkg::ST_DRAIN: begin
					if (drain_last) begin
						state_q <= samr_pkg::ST_IDLE;
						play_q  <= play_nxt;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: begin
					state_q <= samr_pkg::ST_IDLE;
					cnt_q   <= '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		req_s1 <= req_d;
	end

endmodule

// ===== src/samr_upd.sv =====
`timescale 1ns / 1ps
// update stage: forwarding, saturating add, write back and result register
module samr_upd (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  vld_s1,
	input  samr_pkg::samr_req_t                   req_s1,
	input  logic signed [samr_pkg::SMP_W-1:0]     rd_data,
	output logic                                  wr_en,
	output logic [samr_pkg::RING_AW-1:0]          wr_addr,
	output logic signed [samr_pkg::SMP_W-1:0]     wr_data,
	output samr_pkg::samr_result_t                result,
	output logic                                  result_strobe
);

	logic                              fwd_vld_q;
	logic [samr_pkg::RING_AW-1:0]      fwd_addr_q;
	logic signed [samr_pkg::SMP_W-1:0] fwd_data_q;
	logic signed [samr_pkg::SMP_W-1:0] cur;
	logic signed [samr_pkg::SMP_W:0]   sum;
	logic signed [samr_pkg::SMP_W-1:0] sat;
	samr_pkg::samr_result_t            res_d;
	samr_pkg::samr_result_t            result_q;
	logic                              strobe_q;

	// the read was issued at the edge that wrote the previous access
	assign cur = (fwd_vld_q && fwd_addr_q == req_s1.addr) ? fwd_data_q : rd_data;
	assign sum = {cur[samr_pkg::SMP_W-1], cur}
		+ {req_s1.sample[samr_pkg::SMP_W-1], req_s1.sample};

	always_comb begin
		if (sum[samr_pkg::SMP_W] != sum[samr_pkg::SMP_W-1]) begin
			sat = sum[samr_pkg::SMP_W] ? samr_pkg::SMP_MIN : samr_pkg::SMP_MAX;
		end else begin
			sat = sum[samr_pkg::SMP_W-1:0];
		end
	end

	assign wr_en   = vld_s1 && (req_s1.drain || req_s1.accepted);
	assign wr_addr = req_s1.addr;
	assign wr_data = req_s1.drain ? '0 : sat;

	always_comb begin
		res_d            = '0;
		res_d.start_hint = samr_pkg::POS_W'(req_s1.hint);
		res_d.last       = req_s1.last;
		if (req_s1.drain) begin
			res_d.kind       = samr_pkg::KIND_DRAIN;
			res_d.out_sample = cur;
		end else begin
			res_d.kind       = samr_pkg::KIND_MIX;
			res_d.next_pos   = samr_pkg::POS_W'(req_s1.next_pos);
			res_d.accepted   = req_s1.accepted;
			res_d.batch_done = req_s1.eob;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_vld_q <= 1'b0;
			strobe_q  <= 1'b0;
		end else begin
			fwd_vld_q <= wr_en;
			strobe_q  <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		fwd_addr_q <= wr_addr;
		fwd_data_q <= wr_data;
		result_q   <= res_d;
	end

	assign result        = result_q;
	assign result_strobe = strobe_q;

endmodule

// ===== src/samr_chk.sv =====
`timescale 1ns / 1ps
// port-level checker for the saturating audio mix ring, with its bind
module samr_chk (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   start,
	input logic                   busy,
	input samr_pkg::samr_item_t   item,
	input samr_pkg::samr_result_t result,
	input logic                   result_strobe
);

	// every accepted transaction shows its first result after the issue and result registers
	a_first_result: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##2 result_strobe)
		else $error("no result two cycles after accept");

	// a mix reply only comes from an accepted mix, through the issue and result registers
	a_mix_origin: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && result.kind == samr_pkg::KIND_MIX
		|-> $past(start && !busy && item.cmd == samr_pkg::CMD_MIX, 2))
		else $error("mix reply without a matching mix transaction");

	// mix replies are single, carry no sample
	a_mix_shape: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && result.kind == samr_pkg::KIND_MIX
		|-> result.last && result.out_sample == '0)
		else $error("malformed mix reply");

	// a drained frame streams without gaps until its last sample
	a_drain_stream: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && result.kind == samr_pkg::KIND_DRAIN && !result.last
		|=> result_strobe && result.kind == samr_pkg::KIND_DRAIN)
		else $error("drained frame interrupted");

endmodule

bind saturating_audio_mix_ring samr_chk u_samr_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.item          (item),
	.result        (result),
	.result_strobe (result_strobe)
);

// ===== tb/saturating_audio_mix_ring_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the saturating audio mix ring with its own ring predictor
module saturating_audio_mix_ring_tb;
	import samr_pkg::*;

	// predicts ring contents and play position, holds the expected results in order
	class mix_ring_scoreboard;
		logic signed [SMP_W-1:0] ring [RING_SIZE];
		int unsigned             play_pos;
		logic [POS_W-1:0]        writer_pos;
		samr_result_t            expected_q [$];
		int                      errors;

		function new();
			foreach (ring[i]) ring[i] = '0;
			play_pos   = 0;
			writer_pos = '0;
			errors     = 0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// called once per accepted command transaction
		function void note_item(samr_item_t it);
			samr_result_t r;
			int unsigned  pos;
			int unsigned  idx;
			int           sum;
			logic [POS_W-1:0] hint;
			hint = POS_W'((play_pos + 2 * FRAME_LEN) % RING_SIZE);
			r = '0;
			r.start_hint = hint;
			if (it.cmd == CMD_MIX) begin
				pos = it.write_pos % RING_SIZE;
				r.kind = KIND_MIX;
				r.batch_done = it.end_of_batch;
				r.last = 1'b1;
				if (pos == play_pos) begin
					r.next_pos = POS_W'(pos);
					r.accepted = 1'b0;
				end else begin
					sum = int'(ring[pos]) + int'(it.sample);
					if (sum > int'(SMP_MAX))
						sum = int'(SMP_MAX);
					else if (sum < int'(SMP_MIN))
						sum = int'(SMP_MIN);
					ring[pos] = SMP_W'(sum);
					r.next_pos = POS_W'((pos + 1) % RING_SIZE);
					r.accepted = 1'b1;
				end
				writer_pos = r.next_pos;
				expected_q.push_back(r);
			end else begin
				r.kind = KIND_DRAIN;
				for (int i = 0; i < FRAME_LEN; i++) begin
					idx = (play_pos + i) % RING_SIZE;
					r.out_sample = ring[idx];
					r.last = (i == FRAME_LEN - 1);
					ring[idx] = '0;
					expected_q.push_back(r);
				end
				play_pos = (play_pos + FRAME_LEN) % RING_SIZE;
			end
		endfunction

		task report(string msg);
			errors++;
			$display("mismatch at %0t: %s", $time, msg);
		endtask

		task check(samr_result_t got);
			samr_result_t exp;
			if (expected_q.size() == 0) begin
				report($sformatf("unexpected result %h", got));
				return;
			end
			exp = expected_q.pop_front();
			if (got.kind !== exp.kind)
				report($sformatf("kind exp %0d got %0d", exp.kind, got.kind));
			if (got.next_pos !== exp.next_pos)
				report($sformatf("next_pos exp %0d got %0d", exp.next_pos, got.next_pos));
			if (got.accepted !== exp.accepted)
				report($sformatf("accepted exp %0d got %0d", exp.accepted, got.accepted));
			if (got.batch_done !== exp.batch_done)
				report($sformatf("batch_done exp %0d got %0d", exp.batch_done,
					got.batch_done));
			if (got.out_sample !== exp.out_sample)
				report($sformatf("out_sample exp %0d got %0d", exp.out_sample,
					got.out_sample));
			if (got.last !== exp.last)
				report($sformatf("last exp %0d got %0d", exp.last, got.last));
			if (got.start_hint !== exp.start_hint)
				report($sformatf("start_hint exp %0d got %0d", exp.start_hint,
					got.start_hint));
		endtask
	endclass

	logic         clk;
	logic         arst_n;
	logic         start;
	logic         busy;
	samr_item_t   item;
	samr_result_t result;
	logic         result_strobe;

	mix_ring_scoreboard sb = new();
	bit no_idle;

	saturating_audio_mix_ring uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.result       (result),
		.result_strobe(result_strobe)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && result_strobe)
			sb.check(result);
	end

	function automatic samr_item_t mix_item(logic [POS_W-1:0] pos,
		logic signed [SMP_W-1:0] smp, logic eob);
		samr_item_t it;
		it.cmd = CMD_MIX;
		it.write_pos = pos;
		it.sample = smp;
		it.end_of_batch = eob;
		return it;
	endfunction

	// mix fields carry junk on a drain, the block must ignore them
	function automatic samr_item_t drain_item();
		samr_item_t it;
		it.cmd = CMD_DRAIN;
		it.write_pos = POS_W'($urandom);
		it.sample = SMP_W'($urandom);
		it.end_of_batch = 1'($urandom);
		return it;
	endfunction

	function automatic logic signed [SMP_W-1:0] draw_sample();
		case ($urandom_range(0, 5))
			0: return SMP_MAX;
			1: return SMP_MIN;
			2: return SMP_W'($signed($urandom_range(0, 128)) - 64);
			default: return SMP_W'($urandom);
		endcase
	endfunction

	// called at a rising edge; returns at the edge that takes the transaction
	task automatic send(samr_item_t it);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		item <= it;
		@(negedge clk);
		while (busy)
			@(negedge clk);
		@(posedge clk);
		sb.note_item(it);
	endtask

	task automatic wait_all_results();
		start <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending() != 0);
	endtask

	initial begin
		int count;
		int next_toggle;
		int len;
		bit paused;
		logic [POS_W-1:0] pos;

		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		no_idle = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// mix at play is rejected, then drain the cleared frame
		send(mix_item(8'd0, SMP_MAX, 1'b1));
		send(drain_item());
		// saturation at both rails, wrap of the writer position, cancel to zero
		send(mix_item(8'd0, SMP_MAX, 1'b0));
		send(mix_item(8'd0, 16'sd1, 1'b0));
		send(mix_item(8'd1, SMP_MIN, 1'b0));
		send(mix_item(8'd1, -16'sd1, 1'b1));
		send(mix_item(8'hFF, 16'sh5555, 1'b1));
		send(mix_item(8'd2, -16'sd1, 1'b0));
		send(mix_item(8'd2, 16'sd1, 1'b0));
		send(mix_item(8'd32, 16'sh1234, 1'b1));
		send(mix_item(8'd33, SMP_MAX, 1'b0));
		send(mix_item(8'd33, SMP_MAX, 1'b0));
		send(mix_item(8'd63, SMP_MIN, 1'b1));
		send(mix_item(8'd63, SMP_MIN, 1'b0));
		wait_all_results();
		// go once round the ring so play wraps and frame zero comes out
		repeat (FRAME_COUNT) send(drain_item());

		count = 0;
		next_toggle = 0;
		paused = 1'b0;
		while (count < 195) begin
			if (count >= next_toggle) begin
				no_idle = ($urandom_range(0, 3) == 0);
				next_toggle = count + $urandom_range(10, 30);
			end
			if (!paused && count >= 100) begin
				wait_all_results();
				paused = 1'b1;
			end
			case ($urandom_range(0, 9))
				0, 1: begin
					send(drain_item());
					count++;
				end
				2: begin
					send(mix_item(POS_W'($urandom), SMP_W'($urandom), 1'($urandom)));
					count++;
				end
				default: begin
					// a writer batch starting near play so it sometimes runs into it
					pos = POS_W'((sb.play_pos + $urandom_range(RING_SIZE - 8,
						RING_SIZE + 2 * FRAME_LEN)) % RING_SIZE);
					len = $urandom_range(1, 16);
					for (int j = 0; j < len; j++) begin
						send(mix_item(pos, draw_sample(), j == len - 1));
						pos = sb.writer_pos;
						count++;
					end
				end
			endcase
		end

		wait_all_results();
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
